@@ rtl/core/chist_pkg.sv @@
// ----------------------------------------------------------------------------
// chist_pkg
// Shared types, widths and reset constants of the cumulative bucket histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package chist_pkg;

    // Field widths fixed by the item and result formats
    localparam int DATA_W    = 32;   // signed Q16.16 sample and bound
    localparam int COUNT_W   = 48;   // saturating bucket counter
    localparam int SUM_W     = 64;   // saturating signed running sum
    localparam int BIDX_W    = 3;    // reported bucket index
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 3;    // configuration register index

    // Programmable bounds and default bucket count
    localparam int NUM_REGS        = 7;
    localparam int NUM_BUCKETS_DEF = 8;

    typedef logic signed [DATA_W-1:0] bound_t;

    // Bounds beyond the programmable ones sit at the largest Q16.16 value
    localparam bound_t BOUND_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // Reset bounds: 0.005, 0.01, 0.025, 0.05, 0.075, 0.1, 0.25 in Q16.16
    localparam bound_t BOUND_RESET [NUM_REGS] = '{
        32'sd328, 32'sd655, 32'sd1638, 32'sd3277, 32'sd4915, 32'sd6554, 32'sd16384
    };

    // Item operations
    typedef enum logic [OP_W-1:0] {
        OP_OBSERVE = 2'd0,
        OP_QUERY   = 2'd1,
        OP_COLLECT = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

endpackage

`default_nettype wire

@@ rtl/core/chist_cfg_if.sv @@
// ----------------------------------------------------------------------------
// chist_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface chist_cfg_if
    import chist_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/chist_item_if.sv @@
// ----------------------------------------------------------------------------
// chist_item_if
// Input item channel: operation and sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface chist_item_if
    import chist_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] sample;

    modport source (output valid, op, sample, input ready);
    modport sink   (input valid, op, sample, output ready);
endinterface

`default_nettype wire

@@ rtl/core/chist_result_if.sv @@
// ----------------------------------------------------------------------------
// chist_result_if
// Result channel: bucket index, bucket count, running sum, last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface chist_result_if
    import chist_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [BIDX_W-1:0]       bucket_index;
    logic [COUNT_W-1:0]      bucket_count;
    logic signed [SUM_W-1:0] sample_sum;
    logic                    last;

    modport source (output valid, bucket_index, bucket_count, sample_sum, last,
                    input ready);
    modport sink   (input valid, bucket_index, bucket_count, sample_sum, last,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/chist_bounds.sv @@
// ----------------------------------------------------------------------------
// chist_bounds
// Bucket bound registers, written through the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module chist_bounds
    import chist_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    chist_cfg_if.sink   cfg,
    output bound_t      bounds [NUM_BUCKETS-1]
);

    // Writes are always taken; out-of-range indexes match no register
    assign cfg.ready = 1'b1;

    for (genvar g = 0; g < NUM_BUCKETS - 1; g++)
    begin : g_bound
        if (g < NUM_REGS)
        begin : g_reg
            bound_t bound_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    bound_reg <= BOUND_RESET[g];
                end
                else if (cfg.valid && (cfg.index == CFG_IDX_W'(g)))
                begin
                    bound_reg <= bound_t'(cfg.data);
                end
            end

            assign bounds[g] = bound_reg;
        end
        else
        begin : g_fixed
            assign bounds[g] = BOUND_MAX;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/chist_classify.sv @@
// ----------------------------------------------------------------------------
// chist_classify
// Compares a sample against every bound: bucket hit mask and first hit.
// ----------------------------------------------------------------------------
`default_nettype none

module chist_classify
    import chist_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    localparam int SEL_W      = $clog2(NUM_BUCKETS)
) (
    input  wire bound_t              sample,
    input  wire bound_t              bounds [NUM_BUCKETS-1],
    output logic [NUM_BUCKETS-1:0]   hit,
    output logic [SEL_W-1:0]         first_idx
);

    // One signed compare per bounded bucket; the last bucket takes everything
    always_comb
    begin
        for (int i = 0; i < NUM_BUCKETS - 1; i++)
        begin
            hit[i] = (sample <= bounds[i]);
        end
        hit[NUM_BUCKETS-1] = 1'b1;
    end

    // Lowest bucket that holds the sample
    always_comb
    begin
        first_idx = SEL_W'(NUM_BUCKETS - 1);
        for (int i = NUM_BUCKETS - 2; i >= 0; i--)
        begin
            if (hit[i])
            begin
                first_idx = SEL_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/chist_engine.sv @@
// ----------------------------------------------------------------------------
// chist_engine
// Item stage register, bucket counters, running sum and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module chist_engine
    import chist_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    localparam int SEL_W      = $clog2(NUM_BUCKETS)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    chist_item_if.sink                item,
    input  wire logic [NUM_BUCKETS-1:0] item_hit,
    input  wire logic [SEL_W-1:0]     item_first,
    chist_result_if.source            result
);

    localparam logic [SEL_W-1:0] LAST_IDX = SEL_W'(NUM_BUCKETS - 1);
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Stage register
    logic                     stg_valid_reg, stg_valid_next;
    op_t                      stg_op_reg;
    bound_t                   stg_sample_reg;
    logic [NUM_BUCKETS-1:0]   stg_hit_reg;
    logic [SEL_W-1:0]         stg_first_reg;
    logic [SEL_W-1:0]         beat_reg, beat_next;

    // Histogram state
    logic [COUNT_W-1:0]       cnt_reg [NUM_BUCKETS];
    logic [COUNT_W-1:0]       cnt_next [NUM_BUCKETS];
    logic signed [SUM_W-1:0]  sum_reg, sum_next;

    // Result register
    logic                     out_valid_reg, out_valid_next;
    logic [BIDX_W-1:0]        out_index_reg;
    logic [COUNT_W-1:0]       out_count_reg;
    logic signed [SUM_W-1:0]  out_sum_reg;
    logic                     out_last_reg;

    logic                     can_emit, stg_fire, stg_last, stg_done, accept, observe;
    logic [SEL_W-1:0]         rd_idx;
    logic signed [SUM_W-1:0]  sample_ext, sum_add;
    logic                     sum_ovf;
    logic [COUNT_W-1:0]       out_count_sel;

    // Handshake between stage and result register
    assign can_emit = !out_valid_reg || result.ready;
    assign stg_fire = stg_valid_reg && ((stg_op_reg == OP_NONE) || can_emit);
    assign stg_last = (stg_op_reg != OP_COLLECT) || (beat_reg == LAST_IDX);
    assign stg_done = stg_fire && stg_last;
    assign item.ready = !stg_valid_reg || stg_done;
    assign accept   = item.valid && item.ready;
    assign observe  = stg_fire && (stg_op_reg == OP_OBSERVE);

    // Stage control
    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        beat_next      = beat_reg;
        if (accept)
        begin
            stg_valid_next = 1'b1;
            beat_next      = '0;
        end
        else
        begin
            if (stg_done)
            begin
                stg_valid_next = 1'b0;
            end
            if (stg_fire && (stg_op_reg == OP_COLLECT))
            begin
                beat_next = beat_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            beat_reg      <= '0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            beat_reg      <= beat_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_op_reg     <= OP_NONE;
            stg_sample_reg <= '0;
            stg_hit_reg    <= '0;
            stg_first_reg  <= '0;
        end
        else if (accept)
        begin
            stg_op_reg     <= op_t'(item.op);
            stg_sample_reg <= item.sample;
            stg_hit_reg    <= item_hit;
            stg_first_reg  <= item_first;
        end
    end

    // Saturating per-bucket increment
    always_comb
    begin
        for (int i = 0; i < NUM_BUCKETS; i++)
        begin
            if (stg_hit_reg[i] && !(&cnt_reg[i]))
            begin
                cnt_next[i] = cnt_reg[i] + 1'b1;
            end
            else
            begin
                cnt_next[i] = cnt_reg[i];
            end
        end
    end

    // Saturating running sum
    assign sample_ext = SUM_W'(stg_sample_reg);
    assign sum_add    = sum_reg + sample_ext;
    assign sum_ovf    = (sum_reg[SUM_W-1] == stg_sample_reg[DATA_W-1])
                        && (sum_add[SUM_W-1] != sum_reg[SUM_W-1]);

    always_comb
    begin
        if (!observe)
        begin
            sum_next = sum_reg;
        end
        else if (sum_ovf)
        begin
            sum_next = stg_sample_reg[DATA_W-1] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_next = sum_add;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            sum_reg <= '0;
        end
        else
        begin
            if (observe)
            begin
                for (int i = 0; i < NUM_BUCKETS; i++)
                begin
                    cnt_reg[i] <= cnt_next[i];
                end
            end
            sum_reg <= sum_next;
        end
    end

    // Bucket reported by this beat
    always_comb
    begin
        rd_idx = stg_first_reg;
        unique case (stg_op_reg)
            OP_OBSERVE: rd_idx = LAST_IDX;
            OP_QUERY:   rd_idx = stg_first_reg;
            OP_COLLECT: rd_idx = beat_reg;
            OP_NONE:    rd_idx = stg_first_reg;
        endcase
    end

    // Observe reports the updated total, others the stored count
    assign out_count_sel = (stg_op_reg == OP_OBSERVE) ? cnt_next[NUM_BUCKETS-1]
                                                      : cnt_reg[rd_idx];

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (stg_fire && (stg_op_reg != OP_NONE))
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_fire && (stg_op_reg != OP_NONE))
        begin
            out_index_reg <= BIDX_W'(rd_idx);
            out_count_reg <= out_count_sel;
            out_sum_reg   <= sum_next;
            out_last_reg  <= stg_last;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.bucket_index = out_index_reg;
    assign result.bucket_count = out_count_reg;
    assign result.sample_sum   = out_sum_reg;
    assign result.last         = out_last_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // Collect beat counter stays within the bucket range
    a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid_reg && (stg_op_reg == OP_COLLECT)) |-> (beat_reg <= LAST_IDX))
        else $error("collect beat counter out of range");

    // A non-final collect beat means the collect still occupies the stage
    a_collect_open: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> stg_valid_reg)
        else $error("open collect beat without collect in stage");

    // Running sum moves only on an observe
    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !observe |=> $stable(sum_reg))
        else $error("running sum changed without observe");

    // Every observe counts in the infinite bucket unless saturated
    a_total_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (observe && !(&cnt_reg[NUM_BUCKETS-1]))
        |=> (cnt_reg[NUM_BUCKETS-1] == $past(cnt_reg[NUM_BUCKETS-1]) + 1'b1))
        else $error("total count not incremented by observe");

endmodule

`default_nettype wire

@@ rtl/core/cumulative_bucket_histogram.sv @@
// ----------------------------------------------------------------------------
// cumulative_bucket_histogram
// Cumulative bucket histogram of signed Q16.16 samples with a running sum.
// ----------------------------------------------------------------------------
// Observe and query items are taken one per clock while the result channel
// keeps up; each gives one result beat via the stage and result registers. A
// collect holds the stage until it gives one beat per bucket, one per cycle
// while results are taken, through the single result register; items behind
// it wait. Op code 3 gives no beat. Bound writes are always taken (ready is
// tied high) and must only be issued while no item is in flight; writes to an
// index past the programmable bounds are dropped. Counters saturate at 2^48-1
// and the sum at the signed 64-bit limits; both clear on reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cumulative_bucket_histogram
    import chist_pkg::*;
#(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    chist_cfg_if.sink        cfg,
    chist_item_if.sink       item,
    chist_result_if.source   result
);

    localparam int SEL_W = $clog2(NUM_BUCKETS);

    bound_t                  bounds [NUM_BUCKETS-1];
    logic [NUM_BUCKETS-1:0]  item_hit;
    logic [SEL_W-1:0]        item_first;

    // Bound registers
    chist_bounds #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_bounds (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .bounds (bounds)
    );

    // Bucket compare on the incoming sample
    chist_classify #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_classify (
        .sample    (item.sample),
        .bounds    (bounds),
        .hit       (item_hit),
        .first_idx (item_first)
    );

    // Counters, sum and result beats
    chist_engine #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_hit   (item_hit),
        .item_first (item_first),
        .result     (result)
    );

endmodule

`default_nettype wire
